// ----- src/scfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial command frame parser package
// Shared constants, phase codes and the types passed between parser and
// frame decoder.
// ----------------------------------------------------------------------------
package scfp_pkg;

	localparam int unsigned BUTTON_COUNT = 16;
	localparam int unsigned STORE_DEPTH  = 14;
	localparam int unsigned STORE_IDX_W  = $clog2(STORE_DEPTH);

	localparam logic [7:0]  SYNC_FIRST     = 8'hFF;
	localparam logic [7:0]  SYNC_SECOND    = 8'hAA;
	localparam logic [7:0]  CMD_REMOTE     = 8'h01;
	localparam logic [7:0]  CMD_VISION     = 8'h02;
	localparam logic [7:0]  REMOTE_MIN_LEN = 8'd14;
	localparam logic [7:0]  VISION_LEN     = 8'd4;
	localparam logic [15:0] LOST_MARKER    = 16'h7FFF;

	// Only the low BUTTON_COUNT button bits can report a new press.
	localparam logic [15:0] BUTTON_MASK = 16'hFFFF >> (16 - BUTTON_COUNT);

	localparam logic FRAME_KIND_REMOTE = 1'b0;
	localparam logic FRAME_KIND_VISION = 1'b1;

	typedef enum logic [5:0] {
		PH_SYNC1 = 6'b000001,
		PH_SYNC2 = 6'b000010,
		PH_CMD   = 6'b000100,
		PH_LEN   = 6'b001000,
		PH_DATA  = 6'b010000,
		PH_CHECK = 6'b100000
	} phase_t;

	typedef logic [STORE_DEPTH-1:0][7:0] store_t;

	// Everything the decoder needs to judge a frame at its checksum byte.
	typedef struct packed {
		logic [7:0]  command;
		logic [7:0]  length;
		logic [7:0]  payload_sum;
		logic [7:0]  frame_sum;
		logic [15:0] prev_buttons;
		logic [31:0] remote_seq;
		logic [31:0] vision_seq;
	} frame_ctx_t;

	typedef struct packed {
		logic               frame_kind;
		logic [31:0]        sequence_number;
		logic [15:0]        buttons_down;
		logic [15:0]        new_presses;
		logic signed [15:0] axis_zero;
		logic signed [15:0] axis_one;
		logic signed [15:0] axis_two;
		logic signed [15:0] axis_three;
		logic signed [15:0] axis_four;
		logic signed [15:0] axis_five;
		logic               target_found;
	} result_t;

	typedef struct packed {
		logic accept_remote;
		logic accept_vision;
	} verdict_t;

endpackage

// ----- src/serial_command_frame_parser.sv -----
// ----------------------------------------------------------------------------
// Serial command frame parser
// Finds FF AA framed commands in a received byte stream and reports accepted
// remote input and vision measurement frames.
// ----------------------------------------------------------------------------
// Usage: each input item is one received byte with the current time. The
// parser hunts for the sync pair FF AA, then reads command, length, payload
// and a checksum byte. A remote frame (command 1, payload sum check, at least
// 14 payload bytes) or a vision frame (command 2, whole-frame sum check,
// exactly 4 payload bytes) yields one result item at its checksum byte; every
// other byte yields nothing.
// Throughput is one byte per cycle while in_stall is low. A byte is captured
// in the input register and processed from there; the result of an accepted
// frame enters the output register when its checksum byte is processed.
// The output register holds a result until it is taken. While a result waits
// under stall, bytes that produce no result still flow; a checksum byte that
// would produce a second result waits in the input register, which raises
// stall on the input side.
// Reset returns the parser to hunting for the first sync byte and clears the
// sequence counters and the remembered buttons. The payload bytes are not
// reset; every byte read is written earlier in the same frame.
module serial_command_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic [31:0]        now_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               frame_kind,
	output logic [31:0]        sequence_number,
	output logic [31:0]        time_stamp,
	output logic [15:0]        buttons_down,
	output logic [15:0]        new_presses,
	output logic signed [15:0] axis_zero,
	output logic signed [15:0] axis_one,
	output logic signed [15:0] axis_two,
	output logic signed [15:0] axis_three,
	output logic signed [15:0] axis_four,
	output logic signed [15:0] axis_five,
	output logic               target_found
);

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [31:0] time_s1;

	// Parser state.
	scfp_pkg::phase_t phase_q;
	logic [7:0]       command_q;
	logic [7:0]       length_q;
	logic [7:0]       position_q;
	logic [7:0]       payload_sum_q;
	logic [7:0]       frame_sum_q;
	logic [15:0]      prev_buttons_q;
	logic [31:0]      remote_seq_q;
	logic [31:0]      vision_seq_q;
	scfp_pkg::store_t store_q;

	scfp_pkg::frame_ctx_t ctx;
	scfp_pkg::verdict_t   verdict;
	scfp_pkg::result_t    result;
	scfp_pkg::result_t    result_q;
	logic [31:0]          time_stamp_q;
	logic                 out_valid_q;

	logic emit;
	logic out_free;
	logic step;
	logic [7:0] position_next;

	assign ctx.command      = command_q;
	assign ctx.length       = length_q;
	assign ctx.payload_sum  = payload_sum_q;
	assign ctx.frame_sum    = frame_sum_q;
	assign ctx.prev_buttons = prev_buttons_q;
	assign ctx.remote_seq   = remote_seq_q;
	assign ctx.vision_seq   = vision_seq_q;

	scfp_frame_decode u_decode (
		.ctx     (ctx),
		.store   (store_q),
		.check   (byte_s1),
		.verdict (verdict),
		.result  (result)
	);

	// A byte produces a result only at the checksum of an accepted frame.
	assign emit = (phase_q == scfp_pkg::PH_CHECK)
		&& (verdict.accept_remote || verdict.accept_vision);
	assign out_free = !out_valid_q || !out_stall;
	// The byte in the input register is processed this cycle.
	assign step = valid_s1 && (out_free || !emit);
	assign in_stall = valid_s1 && !step;
	assign position_next = position_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
			time_s1 <= now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= scfp_pkg::PH_SYNC1;
			command_q      <= '0;
			length_q       <= '0;
			position_q     <= '0;
			payload_sum_q  <= '0;
			frame_sum_q    <= '0;
			prev_buttons_q <= '0;
			remote_seq_q   <= '0;
			vision_seq_q   <= '0;
		end else if (step) begin
			case (phase_q)
				scfp_pkg::PH_SYNC1: begin
					if (byte_s1 == scfp_pkg::SYNC_FIRST) begin
						phase_q <= scfp_pkg::PH_SYNC2;
					end
				end
				scfp_pkg::PH_SYNC2: begin
					// A repeated first sync byte keeps waiting for the second.
					if (byte_s1 == scfp_pkg::SYNC_SECOND) begin
						phase_q     <= scfp_pkg::PH_CMD;
						frame_sum_q <= scfp_pkg::SYNC_FIRST + scfp_pkg::SYNC_SECOND;
					end else if (byte_s1 != scfp_pkg::SYNC_FIRST) begin
						phase_q <= scfp_pkg::PH_SYNC1;
					end
				end
				scfp_pkg::PH_CMD: begin
					command_q   <= byte_s1;
					frame_sum_q <= frame_sum_q + byte_s1;
					phase_q     <= scfp_pkg::PH_LEN;
				end
				scfp_pkg::PH_LEN: begin
					length_q      <= byte_s1;
					frame_sum_q   <= frame_sum_q + byte_s1;
					payload_sum_q <= '0;
					position_q    <= '0;
					// An empty payload goes straight to the checksum.
					phase_q <= (byte_s1 == 8'd0) ? scfp_pkg::PH_CHECK : scfp_pkg::PH_DATA;
				end
				scfp_pkg::PH_DATA: begin
					payload_sum_q <= payload_sum_q + byte_s1;
					frame_sum_q   <= frame_sum_q + byte_s1;
					position_q    <= position_next;
					if (position_next == length_q) begin
						phase_q <= scfp_pkg::PH_CHECK;
					end
				end
				scfp_pkg::PH_CHECK: begin
					phase_q <= scfp_pkg::PH_SYNC1;
					if (verdict.accept_remote) begin
						prev_buttons_q <= result.buttons_down;
						remote_seq_q   <= result.sequence_number;
					end
					if (verdict.accept_vision) begin
						vision_seq_q <= result.sequence_number;
					end
				end
				default: begin
					phase_q <= scfp_pkg::PH_SYNC1;
				end
			endcase
		end
	end

	// Only the first payload bytes are kept; longer payloads still enter the sums.
	always_ff @(posedge clk) begin
		if (step && (phase_q == scfp_pkg::PH_DATA)
			&& (position_q < 8'(scfp_pkg::STORE_DEPTH))) begin
			store_q[position_q[scfp_pkg::STORE_IDX_W-1:0]] <= byte_s1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			result_q     <= result;
			time_stamp_q <= time_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_kind      = result_q.frame_kind;
	assign sequence_number = result_q.sequence_number;
	assign time_stamp      = time_stamp_q;
	assign buttons_down    = result_q.buttons_down;
	assign new_presses     = result_q.new_presses;
	assign axis_zero       = result_q.axis_zero;
	assign axis_one        = result_q.axis_one;
	assign axis_two        = result_q.axis_two;
	assign axis_three      = result_q.axis_three;
	assign axis_four       = result_q.axis_four;
	assign axis_five       = result_q.axis_five;
	assign target_found    = result_q.target_found;

endmodule

// ----- src/scfp_frame_decode.sv -----
// ----------------------------------------------------------------------------
// Frame decoder
// Checks the checksum and length of a finished frame and builds its result.
// ----------------------------------------------------------------------------
module scfp_frame_decode (
	input  scfp_pkg::frame_ctx_t ctx,
	input  scfp_pkg::store_t     store,
	input  logic [7:0]           check,
	output scfp_pkg::verdict_t   verdict,
	output scfp_pkg::result_t    result
);

	logic [15:0] held;
	logic [15:0] dx;
	logic [15:0] dy;

	assign held = {store[1], store[0]};
	assign dx   = {store[1], store[0]};
	assign dy   = {store[3], store[2]};

	always_comb begin
		verdict.accept_remote = (ctx.command == scfp_pkg::CMD_REMOTE)
			&& (ctx.payload_sum == check) && (ctx.length >= scfp_pkg::REMOTE_MIN_LEN);
		verdict.accept_vision = (ctx.command == scfp_pkg::CMD_VISION)
			&& (ctx.frame_sum == check) && (ctx.length == scfp_pkg::VISION_LEN);
	end

	always_comb begin
		if (ctx.command == scfp_pkg::CMD_VISION) begin
			result.frame_kind      = scfp_pkg::FRAME_KIND_VISION;
			result.sequence_number = ctx.vision_seq + 32'd1;
			result.buttons_down    = '0;
			result.new_presses     = '0;
			result.axis_zero       = dx;
			result.axis_one        = dy;
			result.axis_two        = '0;
			result.axis_three      = '0;
			result.axis_four       = '0;
			result.axis_five       = '0;
			result.target_found    = (dx != scfp_pkg::LOST_MARKER)
				&& (dy != scfp_pkg::LOST_MARKER);
		end else begin
			result.frame_kind      = scfp_pkg::FRAME_KIND_REMOTE;
			result.sequence_number = ctx.remote_seq + 32'd1;
			result.buttons_down    = held;
			result.new_presses     = held & ~ctx.prev_buttons & scfp_pkg::BUTTON_MASK;
			result.axis_zero       = {store[3], store[2]};
			result.axis_one        = {store[5], store[4]};
			result.axis_two        = {store[7], store[6]};
			result.axis_three      = {store[9], store[8]};
			result.axis_four       = {store[11], store[10]};
			result.axis_five       = {store[13], store[12]};
			result.target_found    = 1'b1;
		end
	end

endmodule
